/* design/cidp_pkg.sv */
// Shared types and constants for the caller-ID message parser.
// Used by the front end, the command queue, the back end and the top level.
// No dependencies.
package cidp_pkg;

   typedef enum logic [3:0] {
      PH_TYPE = 4'b0001,
      PH_LEN  = 4'b0010,
      PH_BODY = 4'b0100,
      PH_CSUM = 4'b1000
   } phase_type;

   typedef logic [1:0] tag_type;
   typedef logic [1:0] kind_type;

   localparam tag_type TAG_DATE   = 2'd0;
   localparam tag_type TAG_TIME   = 2'd1;
   localparam tag_type TAG_NUM    = 2'd2;
   localparam tag_type TAG_STATUS = 2'd3;

   localparam kind_type KIND_SINGLE  = 2'd0;
   localparam kind_type KIND_MULTI   = 2'd1;
   localparam kind_type KIND_UNKNOWN = 2'd2;

   localparam logic [7:0] TYPE_SINGLE_BYTE = 8'h04;
   localparam logic [7:0] TYPE_MULTI_BYTE  = 8'h80;

   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;

   localparam logic [7:0] POS_TIME_START = 8'd4;
   localparam logic [7:0] POS_NUM_START  = 8'd8;
   localparam logic [7:0] POS_NUM_END    = 8'd18;
   localparam logic [7:0] POS_DATE_SEP   = 8'd2;
   localparam logic [7:0] POS_TIME_SEP   = 8'd6;
   localparam logic [7:0] POS_NUM_SEP_A  = 8'd11;
   localparam logic [7:0] POS_NUM_SEP_B  = 8'd14;
   localparam logic [7:0] POS_MAX        = 8'hFF;

   typedef struct packed {
      logic       two_res;
      logic [7:0] sep_char;
      logic [7:0] main_char;
      tag_type    tag;
      kind_type   kind;
      logic       checksum_ok;
      logic [7:0] param_type;
   } cmd_type;

   typedef struct packed {
      logic [7:0] out_char;
      tag_type    field_tag;
      kind_type   msg_kind;
      logic       checksum_ok;
      logic [7:0] param_type;
      logic       last_of_run;
   } rsp_type;

endpackage

/* design/caller_id_message_parser.sv */
// Caller-ID message parser top level: front end, command queue, back end.
// Depends on cidp_pkg, cidp_front, cidp_cmd_queue and cidp_back.
//
//   Channel   Ports                                   Handshake
//   request   req_data_byte                           req_push / req_full
//   response  rsp_out_char, rsp_field_tag,            rsp_pop / rsp_empty
//             rsp_msg_kind, rsp_checksum_ok,
//             rsp_param_type, rsp_last_of_run
//
// A byte is taken every cycle while the command queue has room.
// The back end sends one result beat per cycle while rsp_pop keeps taking
// them; a byte that inserts a separator takes two beats.
// After its byte is taken, a result passes through the command queue and then the back end's output register.
// Synchronous active-high reset returns the parser to the type-byte phase.
// A stalled response fills the queue of QUEUE_DEPTH commands, then raises req_full.
module caller_id_message_parser import cidp_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_data_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_char,
   output logic [1:0] rsp_field_tag,
   output logic [1:0] rsp_msg_kind,
   output logic       rsp_checksum_ok,
   output logic [7:0] rsp_param_type,
   output logic       rsp_last_of_run
);

   logic    accept;
   logic    cmd_push;
   cmd_type cmd;
   logic    q_full;
   logic    q_empty;
   logic    q_pop;
   cmd_type q_head;
   logic    rsp_valid;
   rsp_type rsp;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   cidp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .cmd_push  (cmd_push),
      .cmd       (cmd)
   );

   cidp_cmd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head     (q_head)
   );

   cidp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .rsp_take  (rsp_pop)
   );

   assign rsp_empty       = !rsp_valid;
   assign rsp_out_char    = rsp.out_char;
   assign rsp_field_tag   = rsp.field_tag;
   assign rsp_msg_kind    = rsp.msg_kind;
   assign rsp_checksum_ok = rsp.checksum_ok;
   assign rsp_param_type  = rsp.param_type;
   assign rsp_last_of_run = rsp.last_of_run;

endmodule

/* design/cidp_front.sv */
// Front end: tracks the message phase, length, position and byte sum,
// and turns each accepted byte into at most one command. Depends on cidp_pkg.
module cidp_front import cidp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] data_byte,
   output logic       cmd_push,
   output cmd_type    cmd
);

   phase_type  phase_ff, phase_in;
   kind_type   kind_ff, kind_in;
   logic [7:0] remaining_ff, remaining_in;
   logic [7:0] position_ff, position_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] ptype_ff, ptype_in;
   logic [7:0] sum_add;
   logic [7:0] rem_dec;

   assign sum_add = sum_ff + data_byte;
   assign rem_dec = (remaining_ff != 8'd0) ? remaining_ff - 8'd1 : 8'd0;

   always_comb begin
      phase_in     = phase_ff;
      kind_in      = kind_ff;
      remaining_in = remaining_ff;
      position_in  = position_ff;
      sum_in       = sum_ff;
      ptype_in     = ptype_ff;
      cmd_push     = 1'b0;
      cmd          = '0;
      cmd.kind     = kind_ff;
      cmd.main_char = data_byte;
      if (accept) begin
         unique case (phase_ff)
            PH_TYPE: begin
               if (data_byte == TYPE_SINGLE_BYTE) begin
                  kind_in = KIND_SINGLE;
               end else if (data_byte == TYPE_MULTI_BYTE) begin
                  kind_in = KIND_MULTI;
               end else begin
                  kind_in = KIND_UNKNOWN;
               end
               sum_in       = data_byte;
               position_in  = 8'd0;
               remaining_in = 8'd0;
               ptype_in     = 8'd0;
               phase_in     = PH_LEN;
            end
            PH_LEN: begin
               sum_in       = sum_add;
               remaining_in = data_byte;
               phase_in     = (data_byte == 8'd0) ? PH_CSUM : PH_BODY;
            end
            PH_BODY: begin
               sum_in = sum_add;
               if (kind_ff == KIND_SINGLE) begin
                  if (position_ff < POS_TIME_START) begin
                     cmd_push     = 1'b1;
                     cmd.tag      = TAG_DATE;
                     cmd.two_res  = (position_ff == POS_DATE_SEP);
                     cmd.sep_char = CHAR_SLASH;
                  end else if (position_ff < POS_NUM_START) begin
                     cmd_push     = 1'b1;
                     cmd.tag      = TAG_TIME;
                     cmd.two_res  = (position_ff == POS_TIME_SEP);
                     cmd.sep_char = CHAR_COLON;
                  end else if (position_ff < POS_NUM_END) begin
                     cmd_push     = 1'b1;
                     cmd.tag      = TAG_NUM;
                     cmd.two_res  = (position_ff == POS_NUM_SEP_A) ||
                                    (position_ff == POS_NUM_SEP_B);
                     cmd.sep_char = CHAR_DASH;
                  end
               end else if (kind_ff == KIND_MULTI && position_ff == 8'd0) begin
                  ptype_in = data_byte;
               end
               if (position_ff != POS_MAX) begin
                  position_in = position_ff + 8'd1;
               end
               remaining_in = rem_dec;
               if (rem_dec == 8'd0) begin
                  phase_in = PH_CSUM;
               end
            end
            PH_CSUM: begin
               cmd_push        = 1'b1;
               cmd.main_char   = 8'd0;
               cmd.tag         = TAG_STATUS;
               cmd.checksum_ok = (sum_add == 8'd0);
               cmd.param_type  = (kind_ff == KIND_MULTI) ? ptype_ff : 8'd0;
               phase_in        = PH_TYPE;
            end
            default: begin
               phase_in = PH_TYPE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_TYPE;
         kind_ff      <= KIND_SINGLE;
         remaining_ff <= 8'd0;
         position_ff  <= 8'd0;
         sum_ff       <= 8'd0;
         ptype_ff     <= 8'd0;
      end else begin
         phase_ff     <= phase_in;
         kind_ff      <= kind_in;
         remaining_ff <= remaining_in;
         position_ff  <= position_in;
         sum_ff       <= sum_in;
         ptype_ff     <= ptype_in;
      end
   end

endmodule

/* design/cidp_cmd_queue.sv */
// Short command queue between the front end and the back end.
// Depends on cidp_pkg for the command type.
module cidp_cmd_queue import cidp_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH)) else $error("queue count exceeds depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop) else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("queue read while empty");
`endif

endmodule

/* design/cidp_back.sv */
// Back end: expands each queued command into one or two result beats and
// holds the current result in an output register. Depends on cidp_pkg.
module cidp_back import cidp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_empty,
   input  cmd_type q_head,
   output logic    q_pop,
   output logic    rsp_valid,
   output rsp_type rsp,
   input  logic    rsp_take
);

   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;
   logic    half_ff, half_in;
   logic    load;

   assign load      = !out_valid_ff || rsp_take;
   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      half_in      = half_ff;
      q_pop        = 1'b0;
      if (load) begin
         if (!q_empty) begin
            out_valid_in       = 1'b1;
            out_in.field_tag   = q_head.tag;
            out_in.msg_kind    = q_head.kind;
            if (q_head.two_res && !half_ff) begin
               out_in.out_char    = q_head.sep_char;
               out_in.checksum_ok = 1'b0;
               out_in.param_type  = 8'd0;
               out_in.last_of_run = 1'b0;
               half_in            = 1'b1;
            end else begin
               out_in.out_char    = q_head.main_char;
               out_in.checksum_ok = q_head.checksum_ok;
               out_in.param_type  = q_head.param_type;
               out_in.last_of_run = 1'b1;
               half_in            = 1'b0;
               q_pop              = 1'b1;
            end
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         half_ff      <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         half_ff      <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

`ifndef SYNTHESIS
   a_half_has_head: assert property (@(posedge clock) disable iff (reset)
      half_ff |-> !q_empty) else $error("separator sent but command gone");
   a_half_two_res: assert property (@(posedge clock) disable iff (reset)
      half_ff |-> q_head.two_res) else $error("separator sent for single command");
   a_sep_pending: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.last_of_run |-> half_ff)
      else $error("separator beat without pending character");
`endif

endmodule
